### hw/rtl/mkcd_pkg.sv
package mkcd_pkg;

    localparam int NUM_KEYS  = 4;
    localparam int LEVEL_W   = 4;
    localparam int KEY_SEL_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int FLAG_W    = 7;
    localparam int TIMER_W   = 16;
    localparam int DIV_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd3;

    localparam logic [DIV_W-1:0]   RST_SAMPLE_PERIOD   = 8'd20;
    localparam logic [TIMER_W-1:0] RST_DOUBLE_WINDOW   = 16'd200;
    localparam logic [TIMER_W-1:0] RST_LONG_PRESS_TIME = 16'd2000;
    localparam logic [TIMER_W-1:0] RST_REPEAT_INTERVAL = 16'd100;

    localparam int F_HOLD   = 0;
    localparam int F_DOWN   = 1;
    localparam int F_UP     = 2;
    localparam int F_SINGLE = 3;
    localparam int F_DOUBLE = 4;
    localparam int F_LONG   = 5;
    localparam int F_REPEAT = 6;

    localparam logic [FLAG_W-1:0] MASK_HOLD_ONLY = 7'h01;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef struct packed {
        logic [TIMER_W-1:0] double_window;
        logic [TIMER_W-1:0] long_press_time;
        logic [TIMER_W-1:0] repeat_interval;
    } t_timing_cfg;

    typedef struct packed {
        logic              tick;
        logic              sample;
        logic              pressed;
        logic              clear;
        logic [FLAG_W-1:0] clear_mask;
    } t_lane_ctl;

endpackage

### hw/rtl/mkcd_lane.sv
module mkcd_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mkcd_pkg::t_timing_cfg        i_cfg,
    input  mkcd_pkg::t_lane_ctl          i_ctl,
    output logic [mkcd_pkg::FLAG_W-1:0]  o_flags
);
    import mkcd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HELD      = 3'd1,
        PH_RELEASED  = 3'd2,
        PH_SECOND    = 3'd3,
        PH_LONG_HELD = 3'd4
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_now, n_now;
    logic                r_before, n_before;
    logic [TIMER_W-1:0]  r_timer, n_timer;
    logic [FLAG_W-1:0]   r_flags, n_flags;
    logic [TIMER_W-1:0]  timer_dec;

    always_comb begin
        timer_dec = r_timer;
        if (i_ctl.tick && (r_timer != '0)) begin
            timer_dec = r_timer - 1'b1;
        end
        n_timer  = timer_dec;
        n_phase  = r_phase;
        n_now    = r_now;
        n_before = r_before;
        n_flags  = r_flags;
        if (i_ctl.sample) begin
            n_before = r_now;
            n_now    = i_ctl.pressed;
            n_flags[F_HOLD] = i_ctl.pressed;
            if (i_ctl.pressed && !r_now) begin
                n_flags[F_DOWN] = 1'b1;
            end
            if (!i_ctl.pressed && r_now) begin
                n_flags[F_UP] = 1'b1;
            end
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_ctl.pressed) begin
                        n_timer = i_cfg.long_press_time;
                        n_phase = PH_HELD;
                    end
                end
                PH_HELD: begin
                    if (!i_ctl.pressed) begin
                        n_timer = i_cfg.double_window;
                        n_phase = PH_RELEASED;
                    end else if (timer_dec == '0) begin
                        n_timer = i_cfg.repeat_interval;
                        n_flags[F_LONG] = 1'b1;
                        n_phase = PH_LONG_HELD;
                    end
                end
                PH_RELEASED: begin
                    if (i_ctl.pressed) begin
                        n_flags[F_DOUBLE] = 1'b1;
                        n_phase = PH_SECOND;
                    end else if (timer_dec == '0) begin
                        n_flags[F_SINGLE] = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                PH_SECOND: begin
                    if (!i_ctl.pressed) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_LONG_HELD: begin
                    if (!i_ctl.pressed) begin
                        n_phase = PH_IDLE;
                    end else if (timer_dec == '0) begin
                        n_timer = i_cfg.repeat_interval;
                        n_flags[F_REPEAT] = 1'b1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        if (i_ctl.clear) begin
            n_flags = r_flags & ~i_ctl.clear_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_now    <= 1'b0;
            r_before <= 1'b0;
            r_timer  <= '0;
            r_flags  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_now    <= n_now;
            r_before <= n_before;
            r_timer  <= n_timer;
            r_flags  <= n_flags;
        end
    end

    assign o_flags = r_flags;

    a_press_starts_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.sample && i_ctl.pressed && (r_phase == PH_IDLE)) |=> (r_phase == PH_HELD))
        else $error("Press from idle did not enter the held phase.");

    a_clear_removes_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> ((r_flags & $past(i_ctl.clear_mask)) == '0))
        else $error("Cleared flags are still set.");

    a_hold_tracks_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.sample && !i_ctl.clear) |=> (r_flags[F_HOLD] == r_now))
        else $error("Hold flag differs from the sampled level.");

endmodule

### hw/rtl/mkcd_merge.sv
module mkcd_merge (
    input  logic [mkcd_pkg::FLAG_W-1:0] i_lane_flags [mkcd_pkg::NUM_KEYS],
    input  logic [1:0]                  i_key_index,
    input  logic [mkcd_pkg::FLAG_W-1:0] i_flag_mask,
    output logic                        o_hit,
    output logic [mkcd_pkg::FLAG_W-1:0] o_key_flags,
    output logic [mkcd_pkg::NUM_KEYS-1:0] o_clear_sel
);
    import mkcd_pkg::*;

    logic [KEY_SEL_W-1:0] sel;

    always_comb begin
        if (32'(i_key_index) < NUM_KEYS) begin
            sel = KEY_SEL_W'(i_key_index);
        end else begin
            sel = '0;
        end
        o_key_flags = i_lane_flags[sel];
        o_hit       = ((o_key_flags & i_flag_mask) != '0);
        o_clear_sel = '0;
        if (o_hit && (i_flag_mask != MASK_HOLD_ONLY)) begin
            o_clear_sel[sel] = 1'b1;
        end
    end

endmodule

### hw/rtl/multi_key_click_detector_top.sv
// Four-key click detector with sticky per-key event flags.
// Input channel: i_valid/o_stall with i_action, i_key_levels, i_key_index and
// i_flag_mask. A tick word (action 0) advances every key timer and, every
// sample_period ticks, samples the active-low key levels. A check word
// (action 1) reads one key's flags and clears the masked ones on a hit,
// unless the mask is MASK_HOLD_ONLY. Output channel: o_valid/i_stall with
// o_hit and o_key_flags; each input word yields exactly one output word, in
// order. Tick words report zeros. Each key has its own lane, and a merge
// stage selects the queried key, so one word is accepted every cycle while
// o_stall is low. Each result enters a two-entry output buffer, which lets a
// word be accepted while an earlier result waits; o_stall rises only when
// both entries are occupied by results the receiver has not taken.
// Configuration writes through i_cfg_we/i_cfg_index/i_cfg_data take effect at
// the next clock edge and are expected only while the block is idle.
// Synchronous reset clears all key state, the divider and the output buffer,
// and restores the register defaults.
module multi_key_click_detector_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mkcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mkcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_action,
    input  logic [3:0]                      i_key_levels,
    input  logic [1:0]                      i_key_index,
    input  logic [6:0]                      i_flag_mask,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit,
    output logic [6:0]                      o_key_flags
);
    import mkcd_pkg::*;

    logic [DIV_W-1:0]     r_sample_period;
    t_timing_cfg          r_cfg;
    logic [DIV_W-1:0]     r_div, n_div;
    logic                 in_acc, out_acc, is_tick, is_check, sample;
    logic [FLAG_W-1:0]    lane_flags [NUM_KEYS];
    t_lane_ctl            lane_ctl [NUM_KEYS];
    logic                 sel_hit;
    logic [FLAG_W-1:0]    sel_flags;
    logic [NUM_KEYS-1:0]  clear_sel;
    logic                 res_hit;
    logic [FLAG_W-1:0]    res_flags;

    logic [FLAG_W:0]      r_buf [2];
    logic                 r_wptr, r_rptr;
    logic [1:0]           r_count;

    assign o_stall  = (r_count == 2'd2);
    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = o_valid && !i_stall;
    assign is_tick  = in_acc && (i_action == ACT_TICK);
    assign is_check = in_acc && (i_action == ACT_CHECK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period       <= RST_SAMPLE_PERIOD;
            r_cfg.double_window   <= RST_DOUBLE_WINDOW;
            r_cfg.long_press_time <= RST_LONG_PRESS_TIME;
            r_cfg.repeat_interval <= RST_REPEAT_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SAMPLE_PERIOD:   r_sample_period       <= i_cfg_data[DIV_W-1:0];
                REG_DOUBLE_WINDOW:   r_cfg.double_window   <= i_cfg_data;
                REG_LONG_PRESS_TIME: r_cfg.long_press_time <= i_cfg_data;
                REG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_div  = r_div;
        sample = 1'b0;
        if (is_tick) begin
            n_div = r_div + 1'b1;
            if (n_div >= r_sample_period) begin
                n_div  = '0;
                sample = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= '0;
        end else begin
            r_div <= n_div;
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        always_comb begin
            lane_ctl[k].tick       = is_tick;
            lane_ctl[k].sample     = sample;
            lane_ctl[k].clear      = is_check && clear_sel[k];
            lane_ctl[k].clear_mask = i_flag_mask;
            if (k < LEVEL_W) begin
                lane_ctl[k].pressed = !i_key_levels[k % LEVEL_W];
            end else begin
                lane_ctl[k].pressed = 1'b0;
            end
        end

        mkcd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_ctl   (lane_ctl[k]),
            .o_flags (lane_flags[k])
        );
    end

    mkcd_merge u_merge (
        .i_lane_flags (lane_flags),
        .i_key_index  (i_key_index),
        .i_flag_mask  (i_flag_mask),
        .o_hit        (sel_hit),
        .o_key_flags  (sel_flags),
        .o_clear_sel  (clear_sel)
    );

    assign res_hit   = (i_action == ACT_CHECK) ? sel_hit : 1'b0;
    assign res_flags = (i_action == ACT_CHECK) ? sel_flags : '0;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_buf[r_wptr] <= {res_hit, res_flags};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (in_acc) begin
                r_wptr <= !r_wptr;
            end
            if (out_acc) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    assign o_valid     = (r_count != 2'd0);
    assign o_hit       = r_buf[r_rptr][FLAG_W];
    assign o_key_flags = r_buf[r_rptr][FLAG_W-1:0];

endmodule

### tb/multi_key_click_detector_top_test.sv
`timescale 1ns / 1ps

module multi_key_click_detector_top_test;
    import mkcd_pkg::*;

    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct packed {
        logic       action;
        logic [3:0] levels;
        logic [1:0] key_index;
        logic [6:0] mask;
    } t_word;

    typedef struct packed {
        logic       hit;
        logic [6:0] flags;
    } t_report;

    typedef enum logic [2:0] {
        PHASE_IDLE,
        PHASE_HELD,
        PHASE_RELEASED,
        PHASE_SECOND,
        PHASE_LONG
    } t_click_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_action = 1'b0;
    logic [3:0]            i_key_levels = '1;
    logic [1:0]            i_key_index = '0;
    logic [6:0]            i_flag_mask = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_hit;
    logic [6:0]            o_key_flags;

    multi_key_click_detector_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_key_levels(i_key_levels),
        .i_key_index (i_key_index),
        .i_flag_mask (i_flag_mask),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_key_flags (o_key_flags)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicted detector state and settings.
    logic [DIV_W-1:0]   cfg_sample_period;
    logic [TIMER_W-1:0] cfg_double_window;
    logic [TIMER_W-1:0] cfg_long_press_time;
    logic [TIMER_W-1:0] cfg_repeat_interval;
    logic [DIV_W-1:0]   det_divider;
    logic               det_pressed     [NUM_KEYS];
    logic               det_was_pressed [NUM_KEYS];
    t_click_phase       det_phase       [NUM_KEYS];
    logic [TIMER_W-1:0] det_timer       [NUM_KEYS];
    logic [FLAG_W-1:0]  det_flags       [NUM_KEYS];

    t_word   queued_words[$];
    t_report awaited_reports[$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_off_requests = 0;

    logic [3:0] stim_levels = '1;
    int         stim_hold_left [4] = '{0, 0, 0, 0};

    function automatic void reset_detector();
        cfg_sample_period   = RST_SAMPLE_PERIOD;
        cfg_double_window   = RST_DOUBLE_WINDOW;
        cfg_long_press_time = RST_LONG_PRESS_TIME;
        cfg_repeat_interval = RST_REPEAT_INTERVAL;
        det_divider = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            det_pressed[k]     = 1'b0;
            det_was_pressed[k] = 1'b0;
            det_phase[k]       = PHASE_IDLE;
            det_timer[k]       = '0;
            det_flags[k]       = '0;
        end
    endfunction

    function automatic void sample_key(input int k, input logic [3:0] levels);
        logic              now;
        logic [FLAG_W-1:0] fl;
        now = (k < LEVEL_W) ? !levels[k] : 1'b0;
        fl = det_flags[k];
        det_was_pressed[k] = det_pressed[k];
        det_pressed[k] = now;
        fl[F_HOLD] = now;
        if (now && !det_was_pressed[k]) fl[F_DOWN] = 1'b1;
        if (!now && det_was_pressed[k]) fl[F_UP] = 1'b1;
        case (det_phase[k])
            PHASE_IDLE: begin
                if (now) begin
                    det_timer[k] = cfg_long_press_time;
                    det_phase[k] = PHASE_HELD;
                end
            end
            PHASE_HELD: begin
                if (!now) begin
                    det_timer[k] = cfg_double_window;
                    det_phase[k] = PHASE_RELEASED;
                end else if (det_timer[k] == 0) begin
                    det_timer[k] = cfg_repeat_interval;
                    fl[F_LONG] = 1'b1;
                    det_phase[k] = PHASE_LONG;
                end
            end
            PHASE_RELEASED: begin
                if (now) begin
                    fl[F_DOUBLE] = 1'b1;
                    det_phase[k] = PHASE_SECOND;
                end else if (det_timer[k] == 0) begin
                    fl[F_SINGLE] = 1'b1;
                    det_phase[k] = PHASE_IDLE;
                end
            end
            PHASE_SECOND: begin
                if (!now) det_phase[k] = PHASE_IDLE;
            end
            PHASE_LONG: begin
                if (!now) begin
                    det_phase[k] = PHASE_IDLE;
                end else if (det_timer[k] == 0) begin
                    det_timer[k] = cfg_repeat_interval;
                    fl[F_REPEAT] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        det_flags[k] = fl;
    endfunction

    function automatic t_report compute_report(input t_word w);
        t_report           r;
        int                sel;
        logic [FLAG_W-1:0] fl;
        r = '0;
        if (w.action == ACT_TICK) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (det_timer[k] != 0) det_timer[k] = det_timer[k] - 1'b1;
            end
            det_divider = det_divider + 1'b1;
            if (det_divider >= cfg_sample_period) begin
                det_divider = '0;
                for (int k = 0; k < NUM_KEYS; k++) sample_key(k, w.levels);
            end
        end else begin
            sel = int'(w.key_index);
            if (sel >= NUM_KEYS) sel = 0;
            fl = det_flags[sel];
            if ((fl & w.mask) != 0) begin
                if (w.mask != MASK_HOLD_ONLY) det_flags[sel] = fl & ~w.mask;
                r.hit = 1'b1;
            end
            r.flags = fl;
        end
        return r;
    endfunction

    // Sender: offers queued words and records the prediction on acceptance.
    always @(posedge i_clk) begin : sender
        t_word bus_word;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                awaited_reports.push_back(compute_report(bus_word));
            end
            if (!i_valid || !o_stall) begin
                if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    bus_word = queued_words.pop_front();
                    i_valid      <= 1'b1;
                    i_action     <= bus_word.action;
                    i_key_levels <= bus_word.levels;
                    i_key_index  <= bus_word.key_index;
                    i_flag_mask  <= bus_word.mask;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus long hold-offs on request.
    always @(posedge i_clk) begin : receiver
        int hold_off_served;
        int hold_off_left;
        if (!i_rst_n) begin
            hold_off_served = 0;
            hold_off_left = 0;
            i_stall <= 1'b0;
        end else if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            hold_off_left = HOLD_OFF_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_off_left != 0) begin
            hold_off_left = hold_off_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_reports.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected word: hit %0d flags %02h", o_hit, o_key_flags);
            end else begin
                want = awaited_reports.pop_front();
                if (o_hit !== want.hit || o_key_flags !== want.flags) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected hit %0d flags %02h, got hit %0d flags %02h",
                                 want.hit, want.flags, o_hit, o_key_flags);
                end
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            REG_SAMPLE_PERIOD:   cfg_sample_period   = value[DIV_W-1:0];
            REG_DOUBLE_WINDOW:   cfg_double_window   = value;
            REG_LONG_PRESS_TIME: cfg_long_press_time = value;
            REG_REPEAT_INTERVAL: cfg_repeat_interval = value;
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(input int sp, input int dw, input int lp, input int ri);
        write_register(REG_SAMPLE_PERIOD, CFG_DATA_W'(sp));
        write_register(REG_DOUBLE_WINDOW, CFG_DATA_W'(dw));
        write_register(REG_LONG_PRESS_TIME, CFG_DATA_W'(lp));
        write_register(REG_REPEAT_INTERVAL, CFG_DATA_W'(ri));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (queued_words.size() != 0 || i_valid || awaited_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_tick(input logic [3:0] levels);
        t_word w;
        w.action = ACT_TICK;
        w.levels = levels;
        w.key_index = 2'($urandom);
        w.mask = 7'($urandom);
        queued_words.push_back(w);
    endtask

    task automatic push_check(input logic [1:0] index, input logic [6:0] mask);
        t_word w;
        w.action = ACT_CHECK;
        w.levels = 4'($urandom);
        w.key_index = index;
        w.mask = mask;
        queued_words.push_back(w);
    endtask

    // Keys follow press and release stretches scaled to the sampling rate,
    // with occasional glitchy random levels mixed in.
    task automatic queue_random_words(input int count, input int tick_pct);
        t_word w;
        int    span;
        span = (cfg_sample_period == 0) ? 26 : int'(cfg_sample_period) * 26;
        if (span > 400) span = 400;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < tick_pct) begin
                for (int k = 0; k < 4; k++) begin
                    if (stim_hold_left[k] == 0) begin
                        stim_levels[k] = ~stim_levels[k];
                        stim_hold_left[k] = $urandom_range(span, 1);
                    end else begin
                        stim_hold_left[k]--;
                    end
                end
                push_tick(($urandom_range(99) < 8) ? 4'($urandom) : stim_levels);
            end else begin
                case ($urandom_range(5))
                    0: w.mask = '0;
                    1: w.mask = MASK_HOLD_ONLY;
                    2: w.mask = '1;
                    3, 4: w.mask = 7'h01 << $urandom_range(6);
                    default: w.mask = 7'($urandom);
                endcase
                push_check(2'($urandom), w.mask);
            end
        end
    endtask

    task automatic run_phase(input int sp, input int dw, input int lp, input int ri,
                             input int send_pct, input int recv_pct,
                             input int count, input int tick_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        apply_settings(sp, dw, lp, ri);
        queue_random_words(count, tick_pct);
        wait_drained();
    endtask

    initial begin
        reset_detector();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A zero sample period samples on every tick.
        apply_settings(0, 2, 3, 1);
        push_check(2'd0, 7'h00);
        push_check(2'd3, 7'h7F);
        push_tick(4'b1111);
        push_tick(4'b0000);
        push_check(2'd1, MASK_HOLD_ONLY);
        push_check(2'd1, MASK_HOLD_ONLY);
        push_check(2'd2, 7'h00);
        repeat (5) push_tick(4'b0000);
        push_check(2'd0, 7'h7F);
        push_tick(4'b1111);
        push_tick(4'b1110);
        repeat (4) push_tick(4'b1111);
        push_check(2'd0, 7'h01 << F_SINGLE);
        push_tick(4'b1101);
        push_tick(4'b1111);
        push_tick(4'b1101);
        push_check(2'd1, 7'h01 << F_DOUBLE);
        push_check(2'd3, 7'h7F);
        push_check(2'd2, 7'h55);
        wait_drained();

        run_phase(1, 4, 8, 3, 0, 0, 200, 70);
        run_phase(2, 3, 6, 2, 77, 0, 200, 70);
        run_phase(1, 0, 0, 0, 0, 77, 200, 70);
        run_phase(3, 10, 20, 5, 35, 35, 200, 70);
        run_phase(255, 65535, 65535, 65535, 0, 0, 560, 90);

        // The receiver holds off while words keep coming, then the sender
        // waits for every outstanding result before going on.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(1, 6, 12, 4);
        hold_off_requests++;
        queue_random_words(100, 70);
        wait_drained();
        queue_random_words(100, 70);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (error_count == 0 && awaited_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### multi_key_click_detector_top.f
hw/rtl/mkcd_pkg.sv
hw/rtl/mkcd_lane.sv
hw/rtl/mkcd_merge.sv
hw/rtl/multi_key_click_detector_top.sv
tb/multi_key_click_detector_top_test.sv
